// ===== hw/rtl/map_line_clip_to_screen_top_macros.svh =====
// Assertion macros shared by the checker.
`ifndef MAP_LINE_CLIP_TO_SCREEN_TOP_MACROS_SVH
`define MAP_LINE_CLIP_TO_SCREEN_TOP_MACROS_SVH
`define MLC_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("check failed");
`define MLC_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("check failed");
`endif

// ===== hw/rtl/mlcs_pkg.sv =====
package mlcs_pkg;
  localparam int ScreenW = 256;
  localparam int ScreenH = 192;
  localparam int QW = 64;
  localparam int CoordW = 44;
  localparam logic [3:0] OcLeft = 4'd1;
  localparam logic [3:0] OcRight = 4'd2;
  localparam logic [3:0] OcBottom = 4'd4;
  localparam logic [3:0] OcTop = 4'd8;

  typedef enum logic [2:0] {
    StIdle, StMul, StCode, StSetup, StDiv, StApply, StOut
  } state_e;

  typedef enum logic [2:0] {
    CfgLeft = 3'd0, CfgBottom = 3'd1, CfgRight = 3'd2, CfgTop = 3'd3, CfgScale = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EdgeTop, EdgeBottom, EdgeRight, EdgeLeft
  } clip_edge_e;

  // One step of restoring division carried from cell to cell.
  typedef struct packed {
    logic [QW-1:0] rem;
    logic [QW-1:0] num;
    logic [QW-1:0] quo;
  } div_bus_t;

  function automatic logic [3:0] screen_code(input logic signed [CoordW-1:0] x,
                                             input logic signed [CoordW-1:0] y);
    logic [3:0] oc;
    oc = 4'd0;
    if (y < 0) oc = oc | OcTop;
    else if (y >= ScreenH) oc = oc | OcBottom;
    if (x < 0) oc = oc | OcLeft;
    else if (x >= ScreenW) oc = oc | OcRight;
    return oc;
  endfunction
endpackage

// ===== hw/rtl/mlcs_div_cell.sv =====
module mlcs_div_cell (
  input  logic                  clk_i,
  input  logic [mlcs_pkg::QW-1:0] den_i,
  input  mlcs_pkg::div_bus_t    bus_i,
  output mlcs_pkg::div_bus_t    bus_o
);
  logic [mlcs_pkg::QW:0] trial;
  mlcs_pkg::div_bus_t    nxt;

  always_comb begin
    trial = {bus_i.rem, bus_i.num[mlcs_pkg::QW-1]} - {1'b0, den_i};
    nxt.num = {bus_i.num[mlcs_pkg::QW-2:0], 1'b0};
    if (!trial[mlcs_pkg::QW]) begin
      nxt.rem = trial[mlcs_pkg::QW-1:0];
      nxt.quo = {bus_i.quo[mlcs_pkg::QW-2:0], 1'b1};
    end else begin
      nxt.rem = {bus_i.rem[mlcs_pkg::QW-2:0], bus_i.num[mlcs_pkg::QW-1]};
      nxt.quo = {bus_i.quo[mlcs_pkg::QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    bus_o <= nxt;
  end
endmodule

// ===== hw/rtl/mlcs_div_chain.sv =====
module mlcs_div_chain (
  input  logic                    clk_i,
  input  logic [mlcs_pkg::QW-1:0] num_i,
  input  logic [mlcs_pkg::QW-1:0] den_i,
  output logic [mlcs_pkg::QW-1:0] quo_o
);
  mlcs_pkg::div_bus_t bus [mlcs_pkg::QW+1];

  assign bus[0].rem = '0;
  assign bus[0].num = num_i;
  assign bus[0].quo = '0;

  for (genvar g = 0; g < mlcs_pkg::QW; g++) begin : g_cell
    mlcs_div_cell u_cell (.clk_i(clk_i), .den_i(den_i), .bus_i(bus[g]), .bus_o(bus[g+1]));
  end

  assign quo_o = bus[mlcs_pkg::QW].quo;
endmodule

// ===== hw/rtl/map_line_clip_to_screen_top.sv =====
// Clips one map-space line segment to the 256 x 192 pixel screen.
// Input beats on s_axis carry start_x, start_y, end_x, end_y (32-bit 16.16
// each) in tdata. Each input beat yields exactly one output beat on m_axis:
// tdata holds visible, start_col, start_row, end_col, end_row.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i. The user
// must write it only while the block is idle; the block does not enforce this.
// One segment is handled at a time. A segment rejected against the map
// window goes from StMul to StOut, one rejected on screen passes StMul,
// StCode and StOut, and one that needs no clipping passes StMul, StCode,
// StSetup and StOut. Each clip iteration passes through a chain of 64
// divider cells, one quotient bit per cell; at most four iterations are
// made. The next input beat can be taken once the result is loaded.
// A result is held in the output register until m_axis_tready is high; a new
// segment may be accepted meanwhile, but its result waits until the held
// beat has been taken.
// Reset returns the window to zero and the scale to 6912 and empties the
// block.
module map_line_clip_to_screen_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // start_x, start_y, end_x, end_y
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // visible, start_col, start_row, end_col, end_row, zero fill
  output logic [39:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);
  localparam int CW = mlcs_pkg::CoordW;
  localparam int QW = mlcs_pkg::QW;

  mlcs_pkg::state_e state_q, state_d;
  logic signed [31:0] wl_q, wb_q, wr_q, wt_q;
  logic [30:0] scale_q;
  logic signed [31:0] m_q [4];
  logic signed [CW-1:0] s_q [4], s_d [4];
  logic signed [64:0] prod_q [4];
  logic [3:0] oc1_q, oc1_d, oc2_q, oc2_d;
  logic [2:0] iter_q, iter_d;
  logic [6:0] cnt_q, cnt_d;
  logic neg_q, neg_d, first_q, first_d, zero_q, zero_d;
  mlcs_pkg::clip_edge_e edge_q, edge_d;
  logic [QW-1:0] num_q, num_d, den_q, den_d, quo;
  logic vis_q, vis_d;
  logic [39:0] out_q, out_d;
  logic ovalid_q, ovalid_d;
  logic [3:0] wc1, wc2;
  logic signed [CW-1:0] a, b, c, add_base, q_s, tx, ty;
  logic [CW-1:0] ma, mb, mc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= '0; wb_q <= '0; wr_q <= '0; wt_q <= '0;
      scale_q <= 31'd6912;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mlcs_pkg::CfgLeft:   wl_q <= cfg_data_i;
        mlcs_pkg::CfgBottom: wb_q <= cfg_data_i;
        mlcs_pkg::CfgRight:  wr_q <= cfg_data_i;
        mlcs_pkg::CfgTop:    wt_q <= cfg_data_i;
        mlcs_pkg::CfgScale:  scale_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  mlcs_div_chain u_div (.clk_i(clk_i), .num_i(num_q), .den_i(den_q), .quo_o(quo));

  function automatic logic [3:0] wcode(input logic signed [31:0] x,
                                       input logic signed [31:0] y,
                                       input logic signed [31:0] l,
                                       input logic signed [31:0] bo,
                                       input logic signed [31:0] r,
                                       input logic signed [31:0] t);
    logic [3:0] oc;
    oc = 4'd0;
    if (y > t) oc = oc | mlcs_pkg::OcTop;
    else if (y < bo) oc = oc | mlcs_pkg::OcBottom;
    if (x < l) oc = oc | mlcs_pkg::OcLeft;
    else if (x > r) oc = oc | mlcs_pkg::OcRight;
    return oc;
  endfunction

  assign wc1 = wcode(m_q[0], m_q[1], wl_q, wb_q, wr_q, wt_q);
  assign wc2 = wcode(m_q[2], m_q[3], wl_q, wb_q, wr_q, wt_q);

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      for (int i = 0; i < 4; i++) m_q[i] <= s_axis_tdata[32*i +: 32];
    end
    if (state_q == mlcs_pkg::StMul) begin
      prod_q[0] <= (33'(m_q[0]) - 33'(wl_q)) * $signed({1'b0, scale_q});
      prod_q[1] <= (33'(m_q[1]) - 33'(wb_q)) * $signed({1'b0, scale_q});
      prod_q[2] <= (33'(m_q[2]) - 33'(wl_q)) * $signed({1'b0, scale_q});
      prod_q[3] <= (33'(m_q[3]) - 33'(wb_q)) * $signed({1'b0, scale_q});
    end
    for (int i = 0; i < 4; i++) s_q[i] <= s_d[i];
    num_q <= num_d; den_q <= den_d; neg_q <= neg_d; edge_q <= edge_d;
    first_q <= first_d; zero_q <= zero_d; out_q <= out_d; vis_q <= vis_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mlcs_pkg::StIdle;
      ovalid_q <= 1'b0;
      iter_q <= '0; cnt_q <= '0; oc1_q <= '0; oc2_q <= '0;
    end else begin
      state_q <= state_d;
      ovalid_q <= ovalid_d;
      iter_q <= iter_d; cnt_q <= cnt_d; oc1_q <= oc1_d; oc2_q <= oc2_d;
    end
  end

  always_comb begin
    logic [3:0] out_c, nc;
    state_d = state_q; ovalid_d = ovalid_q; iter_d = iter_q; cnt_d = cnt_q;
    oc1_d = oc1_q; oc2_d = oc2_q;
    for (int i = 0; i < 4; i++) s_d[i] = s_q[i];
    num_d = num_q; den_d = den_q; neg_d = neg_q; edge_d = edge_q;
    first_d = first_q; zero_d = zero_q; out_d = out_q; vis_d = vis_q;
    a = '0; b = '0; c = '0; add_base = '0; ma = '0; mb = '0; mc = '0;
    q_s = '0; tx = '0; ty = '0; out_c = '0; nc = '0;
    s_axis_tready = (state_q == mlcs_pkg::StIdle);
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    case (state_q)
      mlcs_pkg::StIdle: begin
        if (s_axis_tvalid && s_axis_tready) state_d = mlcs_pkg::StMul;
      end
      mlcs_pkg::StMul: begin
        if ((wc1 & wc2) != 4'd0) begin
          vis_d = 1'b0; state_d = mlcs_pkg::StOut;
        end else state_d = mlcs_pkg::StCode;
      end
      mlcs_pkg::StCode: begin
        s_d[0] = CW'(prod_q[0] >>> 32);
        s_d[1] = CW'(mlcs_pkg::ScreenH) - CW'(prod_q[1] >>> 32);
        s_d[2] = CW'(prod_q[2] >>> 32);
        s_d[3] = CW'(mlcs_pkg::ScreenH) - CW'(prod_q[3] >>> 32);
        oc1_d = mlcs_pkg::screen_code(s_d[0], s_d[1]);
        oc2_d = mlcs_pkg::screen_code(s_d[2], s_d[3]);
        iter_d = '0;
        state_d = mlcs_pkg::StSetup;
        if ((oc1_d & oc2_d) != 4'd0) begin
          vis_d = 1'b0; state_d = mlcs_pkg::StOut;
        end
      end
      mlcs_pkg::StSetup: begin
        if ((oc1_q | oc2_q) == 4'd0) begin
          vis_d = 1'b1; state_d = mlcs_pkg::StOut;
        end else if (iter_q == 3'd4) begin
          vis_d = 1'b0; state_d = mlcs_pkg::StOut;
        end else begin
          first_d = oc1_q != 4'd0;
          out_c = first_d ? oc1_q : oc2_q;
          if ((out_c & mlcs_pkg::OcTop) != 0) begin
            a = s_q[2] - s_q[0]; b = s_q[1]; c = s_q[1] - s_q[3];
            edge_d = mlcs_pkg::EdgeTop;
          end else if ((out_c & mlcs_pkg::OcBottom) != 0) begin
            a = s_q[2] - s_q[0]; b = s_q[1] - CW'(mlcs_pkg::ScreenH);
            c = s_q[1] - s_q[3]; edge_d = mlcs_pkg::EdgeBottom;
          end else if ((out_c & mlcs_pkg::OcRight) != 0) begin
            a = s_q[3] - s_q[1]; b = CW'(mlcs_pkg::ScreenW - 1) - s_q[0];
            c = s_q[2] - s_q[0]; edge_d = mlcs_pkg::EdgeRight;
          end else begin
            a = s_q[3] - s_q[1]; b = -s_q[0]; c = s_q[2] - s_q[0];
            edge_d = mlcs_pkg::EdgeLeft;
          end
          ma = a[CW-1] ? -a : a; mb = b[CW-1] ? -b : b; mc = c[CW-1] ? -c : c;
          neg_d = (a[CW-1] ^ b[CW-1]) ^ c[CW-1];
          zero_d = c == 0;
          num_d = QW'(ma[31:0]) * QW'(mb[31:0]);
          den_d = zero_d ? QW'(1) : QW'(mc);
          cnt_d = '0;
          state_d = mlcs_pkg::StDiv;
        end
      end
      mlcs_pkg::StDiv: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(QW)) state_d = mlcs_pkg::StApply;
      end
      mlcs_pkg::StApply: begin
        q_s = zero_q ? '0 : CW'(quo);
        if (neg_q) q_s = -q_s;
        case (edge_q)
          mlcs_pkg::EdgeTop: begin tx = s_q[0] + q_s; ty = '0; end
          mlcs_pkg::EdgeBottom: begin
            tx = s_q[0] + q_s; ty = CW'(mlcs_pkg::ScreenH - 1);
          end
          mlcs_pkg::EdgeRight: begin
            ty = s_q[1] + q_s; tx = CW'(mlcs_pkg::ScreenW - 1);
          end
          default: begin ty = s_q[1] + q_s; tx = '0; end
        endcase
        nc = mlcs_pkg::screen_code(tx, ty);
        if (first_q) begin
          s_d[0] = tx; s_d[1] = ty; oc1_d = nc;
        end else begin
          s_d[2] = tx; s_d[3] = ty; oc2_d = nc;
        end
        iter_d = iter_q + 3'd1;
        state_d = mlcs_pkg::StSetup;
        if ((oc1_d & oc2_d) != 4'd0) begin
          vis_d = 1'b0; state_d = mlcs_pkg::StOut;
        end
      end
      mlcs_pkg::StOut: begin
        if (!ovalid_q) begin
          out_d = vis_q ? {7'd0, s_q[3][7:0], s_q[2][7:0], s_q[1][7:0],
                           s_q[0][7:0], 1'b1} : '0;
          ovalid_d = 1'b1;
          state_d = mlcs_pkg::StIdle;
        end
      end
      default: state_d = mlcs_pkg::StIdle;
    endcase
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = out_q;
endmodule

// ===== hw/rtl/mlcs_checker.sv =====
`include "map_line_clip_to_screen_top_macros.svh"
module mlcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  `MLC_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `MLC_ASSERT_IMP(a_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata == 40'd0)
  `MLC_ASSERT_IMP(a_rows, clk_i, rst_ni, m_axis_tvalid, (m_axis_tdata[16:9] < 8'd192) && (m_axis_tdata[32:25] < 8'd192))
  `MLC_ASSERT_NXT(a_take, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

bind map_line_clip_to_screen_top mlcs_checker u_chk (.*);
